>>> sv/psp_pkg.sv
package psp_pkg;

  localparam int BYTE_W   = 8;
  localparam int OFS_W    = 13;
  localparam int LEN_W    = 12;
  localparam int PROG_W   = 16;
  localparam int PID_W    = 13;
  localparam int STAT_W   = 2;
  localparam int STORED_W = 7;
  localparam int SHIFT_W  = 24;
  localparam int SID_W    = 16;
  localparam int VER_W    = 5;
  localparam int TDATA_W  = 40;

  localparam logic [OFS_W-1:0] OFS_TABLE_ID = 13'd0;
  localparam logic [OFS_W-1:0] OFS_LEN_HI   = 13'd1;
  localparam logic [OFS_W-1:0] OFS_LEN_LO   = 13'd2;
  localparam logic [OFS_W-1:0] OFS_SID_HI   = 13'd3;
  localparam logic [OFS_W-1:0] OFS_SID_LO   = 13'd4;
  localparam logic [OFS_W-1:0] OFS_VERSION  = 13'd5;
  localparam logic [OFS_W-1:0] OFS_SEC_NUM  = 13'd6;
  localparam logic [OFS_W-1:0] OFS_LAST_SEC = 13'd7;
  localparam logic [OFS_W-1:0] OFS_ENTRIES  = 13'd8;
  localparam logic [OFS_W-1:0] OFS_MAX      = 13'h1fff;

  localparam logic [LEN_W-1:0] LEN_FIXED    = 12'd9;

  localparam logic [BYTE_W-1:0] HDR_NIBBLE_MASK = 8'hf0;
  localparam logic [BYTE_W-1:0] HDR_NIBBLE      = 8'hb0;
  localparam logic [BYTE_W-1:0] LEN_HI_MASK     = 8'h0f;

  localparam logic [STAT_W-1:0] ST_NEW   = 2'd0;
  localparam logic [STAT_W-1:0] ST_SAME  = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD   = 2'd2;
  localparam logic [STAT_W-1:0] ST_TRUNC = 2'd3;

  localparam logic KIND_ENTRY  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [PROG_W-1:0]   program_number;
    logic [PID_W-1:0]    map_pid;
    logic [STAT_W-1:0]   section_status;
    logic                table_overflow;
    logic [STORED_W-1:0] programs_stored;
  } result_t;

endpackage

>>> sv/psp_core.sv
module psp_core #(
  parameter int MAX_PROGRAMS = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [psp_pkg::BYTE_W-1:0]  data_byte,
  input  logic                        last_byte,
  output logic                        res_valid,
  output psp_pkg::result_t            res
);

  localparam int COUNT_W = $clog2(MAX_PROGRAMS + 1);
  localparam int ADDR_W  = (MAX_PROGRAMS > 1) ? $clog2(MAX_PROGRAMS) : 1;
  localparam int ENTRY_W = psp_pkg::PROG_W + psp_pkg::PID_W;

  logic [psp_pkg::OFS_W-1:0]   byte_offset, byte_offset_next;
  logic [psp_pkg::LEN_W-1:0]   declared_length, declared_length_next;
  logic [psp_pkg::SID_W-1:0]   pending_stream_id, pending_stream_id_next;
  logic [psp_pkg::STAT_W-1:0]  verdict, verdict_next;
  logic [psp_pkg::SID_W-1:0]   stored_stream_id, stored_stream_id_next;
  logic [psp_pkg::VER_W-1:0]   stored_version, stored_version_next;
  logic                        table_known, table_known_next;
  logic [psp_pkg::SHIFT_W-1:0] entry_shift, entry_shift_next;
  logic [COUNT_W-1:0]          program_count, program_count_next;
  logic                        overflow_seen, overflow_seen_next;

  logic [ENTRY_W-1:0] program_table [MAX_PROGRAMS];

  logic                        wr_en;
  logic [psp_pkg::LEN_W-1:0]   len_diff;
  logic [psp_pkg::LEN_W-3:0]   npairs;
  logic [psp_pkg::OFS_W-1:0]   region_end;
  logic                        decl_end, at_end, entry_done;
  logic [psp_pkg::PROG_W-1:0]  eprog;
  logic [psp_pkg::PID_W-1:0]   epid;
  logic [psp_pkg::STAT_W-1:0]  status;
  logic [psp_pkg::STORED_W-1:0] stored7;

  generate
    if (COUNT_W >= psp_pkg::STORED_W) begin : g_wide
      assign stored7 = program_count_next[psp_pkg::STORED_W-1:0];
    end else begin : g_narrow
      assign stored7 = {{(psp_pkg::STORED_W-COUNT_W){1'b0}}, program_count_next};
    end
  endgenerate

  always_comb begin
    byte_offset_next       = byte_offset;
    declared_length_next   = declared_length;
    pending_stream_id_next = pending_stream_id;
    verdict_next           = verdict;
    stored_stream_id_next  = stored_stream_id;
    stored_version_next    = stored_version;
    table_known_next       = table_known;
    entry_shift_next       = entry_shift;
    program_count_next     = program_count;
    overflow_seen_next     = overflow_seen;
    wr_en                  = 1'b0;
    entry_done             = 1'b0;
    eprog                  = entry_shift[23:8];
    epid                   = {entry_shift[4:0], data_byte};

    len_diff   = declared_length - psp_pkg::LEN_FIXED;
    npairs     = (declared_length >= psp_pkg::LEN_FIXED) ? len_diff[psp_pkg::LEN_W-1:2] : '0;
    region_end = psp_pkg::OFS_ENTRIES + {1'b0, npairs, 2'b00};

    case (byte_offset)
      psp_pkg::OFS_TABLE_ID: begin
        verdict_next = (data_byte != '0) ? psp_pkg::ST_BAD : psp_pkg::ST_NEW;
      end
      psp_pkg::OFS_LEN_HI: begin
        if ((data_byte & psp_pkg::HDR_NIBBLE_MASK) != psp_pkg::HDR_NIBBLE) begin
          verdict_next = psp_pkg::ST_BAD;
        end
        declared_length_next = {data_byte[3:0] & psp_pkg::LEN_HI_MASK[3:0], 8'h00};
      end
      psp_pkg::OFS_LEN_LO: begin
        declared_length_next = {declared_length[11:8], data_byte};
      end
      psp_pkg::OFS_SID_HI: begin
        pending_stream_id_next = {data_byte, 8'h00};
      end
      psp_pkg::OFS_SID_LO: begin
        pending_stream_id_next = {pending_stream_id[15:8], data_byte};
      end
      psp_pkg::OFS_VERSION: begin
        entry_shift_next = {19'd0, data_byte[5:1]};
        if (!data_byte[0]) begin
          verdict_next = psp_pkg::ST_BAD;
        end
      end
      psp_pkg::OFS_SEC_NUM: begin
        if (data_byte != '0) begin
          verdict_next = psp_pkg::ST_BAD;
        end
      end
      psp_pkg::OFS_LAST_SEC: begin
        if (data_byte != '0) begin
          verdict_next = psp_pkg::ST_BAD;
        end
        if (verdict_next != psp_pkg::ST_BAD) begin
          if (table_known && pending_stream_id == stored_stream_id &&
              entry_shift[4:0] == stored_version) begin
            verdict_next = psp_pkg::ST_SAME;
          end else begin
            verdict_next          = psp_pkg::ST_NEW;
            stored_stream_id_next = pending_stream_id;
            stored_version_next   = entry_shift[4:0];
            table_known_next      = 1'b1;
            program_count_next    = '0;
            overflow_seen_next    = 1'b0;
          end
          entry_shift_next = '0;
        end
      end
      default: begin
        if (verdict == psp_pkg::ST_NEW && byte_offset < region_end) begin
          if (byte_offset[1:0] == 2'b11) begin
            entry_shift_next = '0;
            if (eprog != '0) begin
              if (program_count < COUNT_W'(MAX_PROGRAMS)) begin
                wr_en              = 1'b1;
                program_count_next = program_count + 1'b1;
                entry_done         = 1'b1;
              end else begin
                overflow_seen_next = 1'b1;
              end
            end
          end else begin
            entry_shift_next = {entry_shift[15:0], data_byte};
          end
        end
      end
    endcase

    decl_end = (byte_offset >= psp_pkg::OFS_LEN_LO) &&
               ({1'b0, byte_offset} == ({2'b00, declared_length_next} + 14'd2));
    at_end   = last_byte || decl_end;

    if (byte_offset < psp_pkg::OFS_LAST_SEC) begin
      status = (verdict_next == psp_pkg::ST_BAD || decl_end) ? psp_pkg::ST_BAD
                                                               : psp_pkg::ST_TRUNC;
    end else if (decl_end) begin
      status = verdict_next;
    end else begin
      status = (verdict_next == psp_pkg::ST_BAD) ? psp_pkg::ST_BAD : psp_pkg::ST_TRUNC;
    end

    if (at_end) begin
      byte_offset_next = '0;
    end else if (byte_offset < psp_pkg::OFS_MAX) begin
      byte_offset_next = byte_offset + 1'b1;
    end

    res_valid               = at_end || entry_done;
    res.kind                = at_end ? psp_pkg::KIND_STATUS : psp_pkg::KIND_ENTRY;
    res.program_number      = at_end ? '0 : eprog;
    res.map_pid             = at_end ? '0 : epid;
    res.section_status      = at_end ? status : psp_pkg::ST_NEW;
    res.table_overflow      = overflow_seen_next;
    res.programs_stored     = stored7;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset       <= '0;
      declared_length   <= '0;
      pending_stream_id <= '0;
      verdict           <= psp_pkg::ST_NEW;
      stored_stream_id  <= '0;
      stored_version    <= '0;
      table_known       <= 1'b0;
      entry_shift       <= '0;
      program_count     <= '0;
      overflow_seen     <= 1'b0;
    end else if (step) begin
      byte_offset       <= byte_offset_next;
      declared_length   <= declared_length_next;
      pending_stream_id <= pending_stream_id_next;
      verdict           <= verdict_next;
      stored_stream_id  <= stored_stream_id_next;
      stored_version    <= stored_version_next;
      table_known       <= table_known_next;
      entry_shift       <= entry_shift_next;
      program_count     <= program_count_next;
      overflow_seen     <= overflow_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && wr_en) begin
      program_table[program_count[ADDR_W-1:0]] <= {eprog, epid};
    end
  end

endmodule

>>> sv/pat_section_parser.sv
// channel   dir  tdata                        tuser      tlast
// s_axis    in   [7:0] data_byte              -          last_byte
// m_axis    out  program_number, map_pid,     item_kind  -
//                section_status, overflow,
//                programs_stored
//
// one beat per cycle in while no stalled result holds the input stage
// one input register and one result register; beats with no result still
// pass the input stage
// rst is synchronous and clears parser state and both valid flags
// a stalled result holds the input stage once it is full
module pat_section_parser #(
  parameter int MAX_PROGRAMS = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,  // data_byte
  input  logic                         s_axis_tlast,  // last_byte
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // program_number, map_pid, section_status, table_overflow, programs_stored, zero pad
  output logic [psp_pkg::TDATA_W-1:0]  m_axis_tdata,
  output logic                         m_axis_tuser   // item_kind
);

  logic                       in_valid;
  logic [psp_pkg::BYTE_W-1:0] in_data;
  logic                       in_last;
  logic                       advance;
  logic                       res_valid;
  psp_pkg::result_t           res;
  psp_pkg::result_t           out_res;

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  psp_core #(
    .MAX_PROGRAMS(MAX_PROGRAMS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .data_byte (in_data),
    .last_byte (in_last),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_data <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance && res_valid) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res <= res;
    end
  end

  assign m_axis_tuser = out_res.kind;
  assign m_axis_tdata = {1'b0, out_res.programs_stored, out_res.table_overflow,
                         out_res.section_status, out_res.map_pid, out_res.program_number};

endmodule
